// ===== rtl/bfr_pkg.sv =====
// bfr_pkg: shared constants, result and status codes, and the frame job type
// for the block frame receiver. No dependencies.
`timescale 1ns / 1ps

package bfr_pkg;

   // frame layout: block, usage, 8 data bytes, sum, trailer
   localparam int FRAME_LEN  = 12;
   localparam int DATA_BYTES = 8;
   localparam int STORE_LEN  = FRAME_LEN - 1;   // trailer is judged on the fly

   localparam logic [3:0] POS_BLOCK = 4'd0;
   localparam logic [3:0] POS_USAGE = 4'd1;
   localparam logic [3:0] POS_DATA0 = 4'd2;
   localparam logic [3:0] POS_SUM   = 4'd10;
   localparam logic [3:0] POS_TRAIL = 4'd11;

   localparam logic [7:0] TRAILER_MORE  = 8'h0F;
   localparam logic [7:0] TRAILER_END   = 8'hFF;
   localparam logic [7:0] USAGE_PROGRAM = 8'h02;
   localparam logic [7:0] MAX_BLOCKS_RESET = 8'd50;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // input item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   // result kinds (an acknowledge goes out on the link as 0x58 + block)
   localparam logic [1:0] OUT_DATA = 2'd0;
   localparam logic [1:0] OUT_ACK  = 2'd1;
   localparam logic [1:0] OUT_END  = 2'd2;

   // session end status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_BLOCK = 3'd1;
   localparam logic [2:0] ST_BAD_SUM   = 3'd2;
   localparam logic [2:0] ST_BAD_TRAIL = 3'd3;
   localparam logic [2:0] ST_LIMIT     = 3'd4;

   // back-end sequencer steps: 0..7 data bytes, then ack, then end
   localparam logic [3:0] STEP_DATA0 = 4'd0;
   localparam logic [3:0] STEP_ACK   = 4'd8;
   localparam logic [3:0] STEP_END   = 4'd9;

   // one judged frame, handed from front to back
   typedef struct packed {
      logic [DATA_BYTES-1:0][7:0] data;
      logic                       has_data;
      logic                       has_ack;
      logic [7:0]                 ack_block;
      logic                       has_end;
      logic [2:0]                 end_status;
   } job_type;

endpackage

// ===== rtl/bfr_channels.sv =====
// bfr_channels: valid/ready channel interfaces for requests and responses.
// No dependencies.
`timescale 1ns / 1ps

interface blk_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface blk_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       last;

   modport source (output valid, output out_kind, output out_byte, output status,
                   output last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input status,
                   input last, output ready);
endinterface

// ===== rtl/block_frame_receiver_core.sv =====
// block_frame_receiver_core: top level of the block frame receiver.
// Depends on bfr_pkg, bfr_channels, bfr_front, bfr_queue, bfr_back.
//
//   channel  | direction | contents
//   ---------+-----------+-----------------------------------------------
//   req_if   | in        | kind (start / byte), rx_byte
//   rsp_if   | out       | out_kind, out_byte, status, last
//   csr_*    | in        | write enable + max_blocks, no read-back
//
// One request transaction per cycle is accepted while the job queue has room;
// req_if.ready drops only while the QUEUE_DEPTH-entry job queue is full.
// A judged frame gives 1 to 10 responses, one per cycle from the back-end
// sequencer unless rsp_if stalls; the first follows the trailer byte through
// the job queue and the output register. A stalled response holds in the
// output register; the front keeps taking bytes until the queue fills.
// Synchronous reset clears session and queue state; no clearing pass is needed.
`timescale 1ns / 1ps

module block_frame_receiver_core #(
   parameter int QUEUE_DEPTH = bfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   blk_req_if.sink    req_if,
   blk_rsp_if.source  rsp_if,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import bfr_pkg::*;

   job_type push_job, head_job;
   logic    push, pop, full, empty;

   bfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (full),
      .push        (push),
      .push_job    (push_job)
   );

   bfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (full),
      .empty    (empty)
   );

   bfr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .empty    (empty),
      .pop      (pop),
      .rsp      (rsp_if)
   );

endmodule

// ===== rtl/bfr_front.sv =====
// bfr_front: collects frame bytes, judges complete frames, tracks the session
// and pushes one job per judged frame. Depends on bfr_pkg, blk_req_if.
`timescale 1ns / 1ps

module bfr_front (
   input  logic             clock,
   input  logic             reset,
   blk_req_if.sink          req,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             queue_full,
   output logic             push,
   output bfr_pkg::job_type push_job
);
   import bfr_pkg::*;

   logic [7:0] store_ff [STORE_LEN];
   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] exp_ff, exp_in;
   logic       active_ff, active_in;
   logic [7:0] max_blocks_ff;

   logic       accept, take_byte, frame_done;
   logic [8:0] accepted_cnt;
   job_type    job;

   assign req.ready  = !queue_full;
   assign accept     = req.valid && req.ready;
   assign take_byte  = accept && (req.kind == KIND_BYTE) && active_ff;
   assign frame_done = take_byte && (pos_ff == POS_TRAIL);
   assign accepted_cnt = {1'b0, exp_ff} + 9'd1;

   // frame judgement, trailer is the byte arriving now
   always_comb begin
      job = '0;
      for (int i = 0; i < DATA_BYTES; i++) begin
         job.data[i] = store_ff[POS_DATA0 + 4'(i)];
      end
      job.ack_block = exp_ff;
      if (store_ff[POS_BLOCK] != exp_ff) begin
         job.has_end    = 1'b1;
         job.end_status = ST_BAD_BLOCK;
      end else if (store_ff[POS_SUM] != sum_ff) begin
         job.has_end    = 1'b1;
         job.end_status = ST_BAD_SUM;
      end else begin
         job.has_data = (store_ff[POS_USAGE] == USAGE_PROGRAM);
         job.has_ack  = 1'b1;
         if (req.rx_byte == TRAILER_MORE) begin
            if (accepted_cnt >= {1'b0, max_blocks_ff}) begin
               job.has_end    = 1'b1;
               job.end_status = ST_LIMIT;
            end
         end else if (req.rx_byte == TRAILER_END) begin
            job.has_end    = 1'b1;
            job.end_status = ST_OK;
         end else begin
            job.has_end    = 1'b1;
            job.end_status = ST_BAD_TRAIL;
         end
      end
   end

   assign push     = frame_done;
   assign push_job = job;

   // session state
   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      exp_in    = exp_ff;
      active_in = active_ff;
      if (accept && (req.kind == KIND_START)) begin
         pos_in    = '0;
         sum_in    = '0;
         exp_in    = '0;
         active_in = 1'b1;
      end else if (frame_done) begin
         pos_in = '0;
         sum_in = '0;
         if (job.has_end) begin
            active_in = 1'b0;
         end else begin
            exp_in = accepted_cnt[7:0];
         end
      end else if (take_byte) begin
         pos_in = pos_ff + 4'd1;
         if (pos_ff < POS_SUM) begin
            sum_in = sum_ff + req.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         sum_ff        <= '0;
         exp_ff        <= '0;
         active_ff     <= 1'b0;
         max_blocks_ff <= MAX_BLOCKS_RESET;
      end else begin
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         exp_ff    <= exp_in;
         active_ff <= active_in;
         if (csr_wr_en) begin
            max_blocks_ff <= csr_wr_data;
         end
      end
   end

   // frame byte store, trailer not kept
   always_ff @(posedge clock) begin
      if (take_byte && (pos_ff != POS_TRAIL)) begin
         store_ff[pos_ff] <= req.rx_byte;
      end
   end

endmodule

// ===== rtl/bfr_queue.sv =====
// bfr_queue: small FIFO of judged-frame jobs between front and back.
// Depends on bfr_pkg.
`timescale 1ns / 1ps

module bfr_queue #(
   parameter int DEPTH = bfr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bfr_pkg::job_type push_job,
   input  logic             pop,
   output bfr_pkg::job_type head_job,
   output logic             full,
   output logic             empty
);
   import bfr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/bfr_back.sv =====
// bfr_back: walks the head job through data bytes, acknowledge and session end,
// one result per unstalled cycle into a registered output. Depends on bfr_pkg, blk_rsp_if.
`timescale 1ns / 1ps

module bfr_back (
   input  logic             clock,
   input  logic             reset,
   input  bfr_pkg::job_type head_job,
   input  logic             empty,
   output logic             pop,
   blk_rsp_if.source        rsp
);
   import bfr_pkg::*;

   logic       started_ff, started_in;
   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic [2:0] status_ff;
   logic       last_ff;

   logic [3:0] start_step, cur_step;
   logic       load, is_last;
   logic [1:0] res_kind;
   logic [7:0] res_byte;
   logic [2:0] res_status;

   assign start_step = head_job.has_data ? STEP_DATA0 :
                       head_job.has_ack  ? STEP_ACK : STEP_END;
   assign cur_step   = started_ff ? step_ff : start_step;
   assign is_last    = (cur_step == STEP_END) ||
                       ((cur_step == STEP_ACK) && !head_job.has_end);
   assign load       = !empty && (!valid_ff || rsp.ready);
   assign pop        = load && is_last;

   // result for the current step
   always_comb begin
      if (cur_step < STEP_ACK) begin
         res_kind   = OUT_DATA;
         res_byte   = head_job.data[cur_step[2:0]];
         res_status = ST_OK;
      end else if (cur_step == STEP_ACK) begin
         res_kind   = OUT_ACK;
         res_byte   = head_job.ack_block;
         res_status = ST_OK;
      end else begin
         res_kind   = OUT_END;
         res_byte   = '0;
         res_status = head_job.end_status;
      end
   end

   // sequencer
   always_comb begin
      started_in = started_ff;
      step_in    = step_ff;
      if (load) begin
         started_in = !is_last;
         step_in    = cur_step + 4'd1;
      end
      valid_in = load || (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         step_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         step_ff    <= step_in;
         valid_ff   <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= res_kind;
         byte_ff   <= res_byte;
         status_ff <= res_status;
         last_ff   <= is_last;
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_kind = kind_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.status   = status_ff;
   assign rsp.last     = last_ff;

endmodule

// ===== rtl/bfr_checker.sv =====
// bfr_props: port-level assertions for the block frame receiver and the
// bind that attaches them to the top level. Depends on bfr_pkg.
`timescale 1ns / 1ps

module bfr_props (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_status,
   input logic       rsp_last
);
   import bfr_pkg::*;

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_status) && $stable(rsp_last))
      else $error("response changed while stalled");

   // nothing pending right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // data and acknowledge carry ok status and are never last unless ack
   a_nonend_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind != OUT_END) |->
      (rsp_status == ST_OK) && (rsp_out_kind == OUT_ACK || !rsp_last))
      else $error("bad status or last on data/ack response");

   // a session end closes the frame with a zero byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == OUT_END) |-> rsp_last && (rsp_out_byte == 8'd0))
      else $error("session end not last or byte nonzero");

endmodule

bind block_frame_receiver_core bfr_props u_bfr_props (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_out_kind (rsp_if.out_kind),
   .rsp_out_byte (rsp_if.out_byte),
   .rsp_status   (rsp_if.status),
   .rsp_last     (rsp_if.last)
);
